// ===== design/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cell balancing controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int NUM_STACKS      = 8;
	localparam int CELLS_PER_STACK = 12;

	localparam int STK_W   = 3;
	localparam int CELL_W  = 4;
	localparam int MV_W    = 16;
	localparam int TS_W    = 32;
	localparam int REF_W   = 20;
	localparam int MASK_W  = 12;
	localparam int PHASE_W = 2;

	localparam int STK_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int DONE_W = $clog2(NUM_STACKS + 1);

	localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELLS_PER_STACK - 1);
	localparam logic [STK_AW-1:0] LAST_STACK = STK_AW'(NUM_STACKS - 1);

	// result buffer
	localparam int RBUF_DEPTH = 3;
	localparam int RBUF_AW    = $clog2(RBUF_DEPTH);
	localparam int RBUF_CW    = $clog2(RBUF_DEPTH + 1);

	// APB register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_ALLOWED_DIFF = 2'd0,
		REG_MIN_TARGET   = 2'd1,
		REG_DIS_CYCLE    = 2'd2,
		REG_REFRESH      = 2'd3
	} reg_idx_t;

	localparam logic [MV_W-1:0]  RST_ALLOWED_DIFF = MV_W'(20);
	localparam logic [MV_W-1:0]  RST_MIN_TARGET   = MV_W'(3000);
	localparam logic [MV_W-1:0]  RST_DIS_CYCLE    = MV_W'(15000);
	localparam logic [REF_W-1:0] RST_REFRESH      = REF_W'(60 * 1000);

	// per-stack phase, one-hot in storage
	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_COOL  = 4'b0010,
		PH_DIS   = 4'b0100,
		PH_FIN   = 4'b1000
	} phase_t;

	localparam logic [PHASE_W-1:0] CODE_START = 2'd0;
	localparam logic [PHASE_W-1:0] CODE_COOL  = 2'd1;
	localparam logic [PHASE_W-1:0] CODE_DIS   = 2'd2;
	localparam logic [PHASE_W-1:0] CODE_FIN   = 2'd3;

	typedef struct packed {
		phase_t            ph;
		logic [MASK_W-1:0] mask;
		logic [TS_W-1:0]   start_ms;
	} entry_t;

	typedef struct packed {
		logic [STK_W-1:0]   out_stack;
		logic [MASK_W-1:0]  discharge_mask;
		logic [MV_W-1:0]    target_mv;
		logic [PHASE_W-1:0] stack_phase;
		logic               update_last;
		logic               all_finished;
		logic [TS_W-1:0]    since_refresh_ms;
	} res_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		unique case (ph)
			PH_START: code = CODE_START;
			PH_COOL:  code = CODE_COOL;
			PH_DIS:   code = CODE_DIS;
			PH_FIN:   code = CODE_FIN;
			default:  code = CODE_START;
		endcase
		return code;
	endfunction

	function automatic logic [MASK_W-1:0] cell_bit(input logic [CELL_W-1:0] cidx);
		logic [MASK_W-1:0] b;
		b = '0;
		if ({28'd0, cidx} < 32'(MASK_W))
			b = MASK_W'(1) << cidx;
		return b;
	endfunction

endpackage

// ===== design/cbc_if.sv =====
// ----------------------------------------------------------------------------
// cbc_if
// Valid/ready channels of the cell balancing controller: sample and result.
// ----------------------------------------------------------------------------
interface cbc_sample_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  stack_index;
	logic [3:0]  cell_index;
	logic [15:0] cell_voltage_mv;
	logic [15:0] global_min_mv;
	logic [31:0] timestamp_ms;

	modport source (
		output valid, req_type, stack_index, cell_index, cell_voltage_mv,
			global_min_mv, timestamp_ms,
		input ready
	);
	modport sink (
		input valid, req_type, stack_index, cell_index, cell_voltage_mv,
			global_min_mv, timestamp_ms,
		output ready
	);
endinterface

interface cbc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_stack;
	logic [11:0] discharge_mask;
	logic [15:0] target_mv;
	logic [1:0]  stack_phase;
	logic        update_last;
	logic        all_finished;
	logic [31:0] since_refresh_ms;

	modport source (
		output valid, out_stack, discharge_mask, target_mv, stack_phase,
			update_last, all_finished, since_refresh_ms,
		input ready
	);
	modport sink (
		input valid, out_stack, discharge_mask, target_mv, stack_phase,
			update_last, all_finished, since_refresh_ms,
		output ready
	);
endinterface

// ===== design/cbc_result_buf.sv =====
// ----------------------------------------------------------------------------
// cbc_result_buf
// Small result queue between the step stage and the result channel.
// ----------------------------------------------------------------------------
module cbc_result_buf
	import cbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  res_t               push_data,
	output logic [RBUF_CW-1:0] fill,
	cbc_result_if.source       result
);

	res_t               slot_q [RBUF_DEPTH];
	logic [RBUF_AW-1:0] wr_ptr_q;
	logic [RBUF_AW-1:0] rd_ptr_q;
	logic [RBUF_CW-1:0] cnt_q;
	logic               pop;
	res_t               head;

	assign pop  = result.valid && result.ready;
	assign fill = cnt_q;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == RBUF_AW'(RBUF_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == RBUF_AW'(RBUF_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign result.valid            = (cnt_q != '0);
	assign result.out_stack        = head.out_stack;
	assign result.discharge_mask   = head.discharge_mask;
	assign result.target_mv        = head.target_mv;
	assign result.stack_phase      = head.stack_phase;
	assign result.update_last      = head.update_last;
	assign result.all_finished     = head.all_finished;
	assign result.since_refresh_ms = head.since_refresh_ms;

endmodule

// ===== design/cell_balancing_controller.sv =====
// ----------------------------------------------------------------------------
// cell_balancing_controller
// Passive cell balancing: per-stack phase machine over a stack state memory.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock. A sample is a cell voltage; the first
// sample of an update (stack 0, cell 0) may reload the balancing target,
// and the last cell of a stack steps that stack's phase machine
// (start -> cooldown -> discharging <-> cooldown -> finished) and produces
// one result beat with the discharge mask. A restart beat returns all
// stacks to start and clears the target; it produces no result. Samples
// with stack or cell out of range are dropped. A sample is registered into
// stage 1 and its result into the result queue. The sustained rate of one
// beat per cycle is set by the stack state memory: it is read when the
// beat is taken and written back in the cycle after, and a back-to-back
// access to the same stack is served from the write data. sample.ready
// drops only when the three-entry result queue plus the result in flight
// would overflow, so it depends only on internal state. Reset and restart
// clear the stack memory through one valid flag per stack; no clearing
// pass is needed. Registers sit on an APB port at byte addresses 0, 4, 8
// and 12 and may be changed only while the block is idle.
// ----------------------------------------------------------------------------
module cell_balancing_controller
	import cbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	cbc_sample_if.sink         sample,
	cbc_result_if.source       result
);

	// ---------------- configuration registers ----------------
	logic [MV_W-1:0]  allowed_diff_q;
	logic [MV_W-1:0]  min_target_q;
	logic [MV_W-1:0]  dis_cycle_q;
	logic [REF_W-1:0] refresh_q;
	reg_idx_t         reg_sel;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_diff_q <= RST_ALLOWED_DIFF;
			min_target_q   <= RST_MIN_TARGET;
			dis_cycle_q    <= RST_DIS_CYCLE;
			refresh_q      <= RST_REFRESH;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ALLOWED_DIFF: allowed_diff_q <= pwdata[MV_W-1:0];
				REG_MIN_TARGET:   min_target_q   <= pwdata[MV_W-1:0];
				REG_DIS_CYCLE:    dis_cycle_q    <= pwdata[MV_W-1:0];
				REG_REFRESH:      refresh_q      <= pwdata[REF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ALLOWED_DIFF: prdata = PDATA_W'(allowed_diff_q);
			REG_MIN_TARGET:   prdata = PDATA_W'(min_target_q);
			REG_DIS_CYCLE:    prdata = PDATA_W'(dis_cycle_q);
			REG_REFRESH:      prdata = PDATA_W'(refresh_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------- stage 0: accept, top-two, memory read ----------------
	logic               take;
	logic               restart;
	logic               in_range;
	logic               is_sample;
	logic [STK_AW-1:0]  rd_addr;
	logic               push;
	logic [RBUF_CW-1:0] fill;

	// worst case: queue fill plus the result now in stage 1
	assign sample.ready = (int'(fill) + int'(push)) < RBUF_DEPTH;

	assign take      = sample.valid && sample.ready;
	assign restart   = take && sample.req_type;
	assign in_range  = (32'(sample.stack_index) < NUM_STACKS)
		&& (32'(sample.cell_index) < CELLS_PER_STACK);
	assign is_sample = take && !sample.req_type && in_range;
	assign rd_addr   = sample.stack_index[STK_AW-1:0];

	// running top-two of the current stack; first index wins ties
	logic [MV_W-1:0]   best_lvl_q;
	logic [CELL_W-1:0] best_cell_q;
	logic [MV_W-1:0]   run_lvl_q;
	logic [CELL_W-1:0] run_cell_q;
	logic              run_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_lvl_q  <= '0;
			best_cell_q <= '0;
			run_lvl_q   <= '0;
			run_cell_q  <= '0;
			run_vld_q   <= 1'b0;
		end else if (restart) begin
			best_lvl_q  <= '0;
			best_cell_q <= '0;
			run_lvl_q   <= '0;
			run_cell_q  <= '0;
			run_vld_q   <= 1'b0;
		end else if (is_sample) begin
			priority if (sample.cell_index == '0) begin
				best_lvl_q  <= sample.cell_voltage_mv;
				best_cell_q <= '0;
				run_lvl_q   <= '0;
				run_cell_q  <= '0;
				run_vld_q   <= 1'b0;
			end else if (sample.cell_voltage_mv > best_lvl_q) begin
				run_lvl_q   <= best_lvl_q;
				run_cell_q  <= best_cell_q;
				run_vld_q   <= 1'b1;
				best_lvl_q  <= sample.cell_voltage_mv;
				best_cell_q <= sample.cell_index;
			end else if (!run_vld_q || sample.cell_voltage_mv > run_lvl_q) begin
				run_lvl_q   <= sample.cell_voltage_mv;
				run_cell_q  <= sample.cell_index;
				run_vld_q   <= 1'b1;
			end
		end
	end

	// stack state memory, registered read, written back from stage 1
	entry_t            stack_mem [NUM_STACKS];
	logic [NUM_STACKS-1:0] vld_q;
	logic              wr_en;
	logic [STK_AW-1:0] wr_addr;
	entry_t            wr_data;
	logic              fwd;

	assign fwd = wr_en && (wr_addr == rd_addr);

	// stage 1 pipeline registers
	logic              valid_s1;
	logic              restart_s1;
	logic              first_s1;
	logic              step_s1;
	logic              last_s1;
	logic [STK_AW-1:0] stack_s1;
	logic [TS_W-1:0]   ts_s1;
	logic [MV_W-1:0]   gmin_s1;
	entry_t            ent_raw_s1;
	logic              ent_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[wr_addr] <= wr_data;
		if (take) begin
			ent_raw_s1 <= fwd ? wr_data : stack_mem[rd_addr];
			stack_s1   <= rd_addr;
			ts_s1      <= sample.timestamp_ms;
			gmin_s1    <= sample.global_min_mv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			valid_s1   <= 1'b0;
			restart_s1 <= 1'b0;
			first_s1   <= 1'b0;
			step_s1    <= 1'b0;
			last_s1    <= 1'b0;
			ent_vld_s1 <= 1'b0;
		end else begin
			// restart is younger than the write in stage 1, so it wins
			if (restart)
				vld_q <= '0;
			else if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			valid_s1   <= take;
			restart_s1 <= restart;
			first_s1   <= is_sample && (sample.stack_index == '0)
				&& (sample.cell_index == '0);
			step_s1    <= is_sample && (sample.cell_index == LAST_CELL);
			last_s1    <= (rd_addr == LAST_STACK);
			if (take)
				ent_vld_s1 <= fwd || vld_q[rd_addr];
		end
	end

	// ---------------- stage 1: target, phase step, write back ----------------
	logic [MV_W-1:0]   target_q;
	logic              target_vld_q;
	logic [TS_W-1:0]   origin_q;
	logic [DONE_W-1:0] done_q;

	entry_t            ent;
	entry_t            nxt;
	logic [MASK_W-1:0] mask_out;
	logic              best_hit;
	logic              run_hit;
	logic [MASK_W-1:0] cool_mask;
	logic [TS_W-1:0]   elapsed;
	logic [TS_W-1:0]   since;
	logic              fin_step;
	logic [DONE_W-1:0] done_base;
	logic [DONE_W-1:0] done_nxt;
	logic              all_fin;
	logic              refresh;
	res_t              res;

	// never-written or restarted stacks read as start
	assign ent = ent_vld_s1 ? ent_raw_s1
		: entry_t'{ph: PH_START, mask: '0, start_ms: '0};

	assign best_hit = (best_lvl_q > target_q)
		&& ((best_lvl_q - target_q) > allowed_diff_q);
	assign run_hit  = run_vld_q && (run_lvl_q > target_q)
		&& ((run_lvl_q - target_q) > allowed_diff_q);
	assign cool_mask = (best_hit ? cell_bit(best_cell_q) : '0)
		| (run_hit ? cell_bit(run_cell_q) : '0);

	assign elapsed = ts_s1 - ent.start_ms;   // wraps safely
	assign since   = ts_s1 - origin_q;

	always_comb begin
		nxt      = ent;
		mask_out = '0;
		fin_step = 1'b0;
		unique case (ent.ph)
			PH_START: begin
				nxt.ph       = PH_COOL;
				nxt.start_ms = ts_s1;
			end
			PH_COOL: begin
				nxt.mask = cool_mask;
				if (!best_hit && !run_hit) begin
					nxt.ph = PH_FIN;
				end else begin
					nxt.ph       = PH_DIS;
					nxt.start_ms = ts_s1;
					mask_out     = cool_mask;
				end
			end
			PH_DIS: begin
				if (elapsed >= TS_W'(dis_cycle_q)) begin
					nxt.ph       = PH_COOL;
					nxt.mask     = '0;
					nxt.start_ms = ts_s1;
				end else begin
					mask_out = ent.mask;
				end
			end
			PH_FIN: fin_step = 1'b1;
			default: ;
		endcase
	end

	// first and last cell of a stack never share a beat
	assign done_base = first_s1 ? '0 : done_q;
	assign done_nxt  = (step_s1 && fin_step && (done_base < DONE_W'(NUM_STACKS)))
		? done_base + 1'b1 : done_base;
	assign all_fin   = last_s1 && (done_nxt >= DONE_W'(NUM_STACKS));

	assign refresh = !target_vld_q || (gmin_s1 > target_q)
		|| (since >= TS_W'(refresh_q));

	assign push    = valid_s1 && step_s1;
	assign wr_en   = push;
	assign wr_addr = stack_s1;
	assign wr_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			target_vld_q <= 1'b0;
			origin_q     <= '0;
			done_q       <= '0;
		end else if (valid_s1) begin
			if (restart_s1) begin
				target_q     <= '0;
				target_vld_q <= 1'b0;
				done_q       <= '0;
			end else begin
				done_q <= done_nxt;
				if (first_s1 && refresh) begin
					target_q     <= (gmin_s1 < min_target_q) ? min_target_q : gmin_s1;
					target_vld_q <= 1'b1;
				end
				if (step_s1 && last_s1 && !all_fin)
					origin_q <= ts_s1;
			end
		end
	end

	always_comb begin
		res.out_stack        = STK_W'(stack_s1);
		res.discharge_mask   = mask_out;
		res.target_mv        = target_q;
		res.stack_phase      = phase_code(nxt.ph);
		res.update_last      = last_s1;
		res.all_finished     = all_fin;
		res.since_refresh_ms = last_s1 ? since : '0;
	end

	cbc_result_buf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.fill      (fill),
		.result    (result)
	);

	// ---------------- assertions ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && (fill == RBUF_CW'(RBUF_DEPTH)) && !(result.valid && result.ready)))
		else $error("result queue overflow");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (vld_q == '0))
		else $error("restart left stack state valid");

	a_mask_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.discharge_mask != '0) |-> result.stack_phase == CODE_DIS)
		else $error("discharge mask outside discharging phase");

	a_never_start: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> res.stack_phase != CODE_START)
		else $error("step left a stack in start");

	a_last_only: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.update_last
			|-> (result.since_refresh_ms == '0) && !result.all_finished)
		else $error("update summary on a non-last result");

endmodule
